FILE: rtl/ipv4p_pkg.sv
// Package for the IPv4 address text parser: parse phases, radix codes,
// character codes, range limits and the character class record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_START  = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Largest value of the last part, by the number of parts before it.
  localparam logic [31:0] MAX_24B = 32'h00ff_ffff;
  localparam logic [31:0] MAX_16B = 32'h0000_ffff;
  localparam logic [31:0] MAX_8B  = 32'h0000_00ff;

  typedef struct packed {
    logic       is_dec;
    logic       is_zero;
    logic       is_hex_letter;
    logic       is_x;
    logic       is_dot;
    logic       is_end;
    logic [3:0] nib;
  } char_class_t;

endpackage

`default_nettype wire

FILE: rtl/ipv4p_in_if.sv
// Input channel of the IPv4 address text parser: valid/ready plus one
// text byte and its start-of-string flag. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ipv4p_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] character;

  modport source (output valid, output start_req, output character, input ready);
  modport sink   (input valid, input start_req, input character, output ready);
endinterface

`default_nettype wire

FILE: rtl/ipv4p_out_if.sv
// Result channel of the IPv4 address text parser: valid/ready plus the
// success flag and the address in network byte order. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ipv4p_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] address;

  modport source (output valid, output valid_res, output address, input ready);
  modport sink   (input valid, input valid_res, input address, output ready);
endinterface

`default_nettype wire

FILE: rtl/ipv4p_char_class.sv
// Character classifier: sorts one text byte into digit, hex letter, dot,
// terminator and radix-prefix classes. Depends on ipv4p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_char_class (
  input  wire logic [7:0]             char_i,
  output ipv4p_pkg::char_class_t      cls_o
);

  logic lower_hex;
  logic upper_hex;
  logic [7:0] dec_off;
  logic [7:0] low_off;
  logic [7:0] up_off;

  assign lower_hex = (char_i >= ipv4p_pkg::CH_LA) && (char_i <= ipv4p_pkg::CH_LF_HEX);
  assign upper_hex = (char_i >= ipv4p_pkg::CH_UA) && (char_i <= ipv4p_pkg::CH_UF);
  assign dec_off   = char_i - ipv4p_pkg::CH_0;
  assign low_off   = char_i - ipv4p_pkg::CH_LA + 8'd10;
  assign up_off    = char_i - ipv4p_pkg::CH_UA + 8'd10;

  always_comb begin
    cls_o.is_dec        = (char_i >= ipv4p_pkg::CH_0) && (char_i <= ipv4p_pkg::CH_9);
    cls_o.is_zero       = (char_i == ipv4p_pkg::CH_0);
    cls_o.is_hex_letter = lower_hex || upper_hex;
    cls_o.is_x          = (char_i == ipv4p_pkg::CH_LX) || (char_i == ipv4p_pkg::CH_UX);
    cls_o.is_dot        = (char_i == ipv4p_pkg::CH_DOT);
    cls_o.is_end        = (char_i == ipv4p_pkg::CH_NUL) || (char_i == ipv4p_pkg::CH_SPACE) ||
                          (char_i == ipv4p_pkg::CH_TAB) || (char_i == ipv4p_pkg::CH_LF) ||
                          (char_i == ipv4p_pkg::CH_VT) || (char_i == ipv4p_pkg::CH_FF) ||
                          (char_i == ipv4p_pkg::CH_CR);
    if (lower_hex) begin
      cls_o.nib = low_off[3:0];
    end else if (upper_hex) begin
      cls_o.nib = up_off[3:0];
    end else begin
      cls_o.nib = dec_off[3:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ipv4_address_text_parser.sv
// Top level of the IPv4 address text parser (dotted decimal, octal, hex).
// Depends on ipv4p_pkg, ipv4p_in_if, ipv4p_out_if and ipv4p_char_class.
//
//  Channel  Dir  Payload                  Moves
//  in_i     in   start_req, character     one text byte per item
//  out_o    out  valid_res, address       one result per terminated string
//
// Each accepted byte updates the parse registers at the end of its clock
// cycle; a result is registered in the output stage and shown the next cycle.
// One byte per cycle is sustained while the result side keeps taking items;
// input ready drops only while a finished result waits in the output stage.
// Reset clears the parser to idle (bytes ignored until a start) and empties
// the output stage.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_address_text_parser (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ipv4p_in_if.sink     in_i,
  ipv4p_out_if.source  out_o
);

  ipv4p_pkg::char_class_t cls;

  ipv4p_pkg::phase_e phase_q, phase_d;
  ipv4p_pkg::radix_e radix_q, radix_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] parts_q [3];
  logic [1:0]  cnt_q, cnt_d;

  logic        out_valid_q;
  logic        res_valid_q, res_valid_d;
  logic [31:0] addr_q, addr_d;

  logic in_fire;
  logic emit;
  logic store;

  ipv4p_char_class u_char_class (
    .char_i (in_i.character),
    .cls_o  (cls)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    ipv4p_pkg::phase_e ph;
    ipv4p_pkg::radix_e rdx;
    logic [31:0] acc;
    logic [1:0]  cnt;
    logic        do_digits;
    logic [31:0] val;
    logic        ok;

    ph        = in_i.start_req ? ipv4p_pkg::PH_START : phase_q;
    rdx       = in_i.start_req ? ipv4p_pkg::RX_DEC : radix_q;
    acc       = in_i.start_req ? 32'd0 : acc_q;
    cnt       = in_i.start_req ? 2'd0 : cnt_q;
    do_digits = 1'b0;
    val       = acc;
    ok        = 1'b1;

    phase_d     = ph;
    radix_d     = rdx;
    acc_d       = acc;
    cnt_d       = cnt;
    store       = 1'b0;
    emit        = 1'b0;
    res_valid_d = 1'b0;
    addr_d      = 32'd0;

    unique case (ph)
      ipv4p_pkg::PH_IDLE: begin
      end
      ipv4p_pkg::PH_START: begin
        if (!cls.is_dec) begin
          emit = 1'b1;
        end else if (cls.is_zero) begin
          acc_d   = 32'd0;
          phase_d = ipv4p_pkg::PH_ZERO;
        end else begin
          acc_d   = {28'd0, cls.nib};
          radix_d = ipv4p_pkg::RX_DEC;
          phase_d = ipv4p_pkg::PH_DIGITS;
        end
      end
      ipv4p_pkg::PH_ZERO: begin
        phase_d = ipv4p_pkg::PH_DIGITS;
        if (cls.is_x) begin
          radix_d = ipv4p_pkg::RX_HEX;
        end else begin
          radix_d   = ipv4p_pkg::RX_OCT;
          do_digits = 1'b1;
        end
      end
      ipv4p_pkg::PH_DIGITS: begin
        do_digits = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_digits) begin
      if (cls.is_dec) begin
        case (radix_d)
          ipv4p_pkg::RX_HEX: acc_d = {acc[27:0], 4'd0} + {28'd0, cls.nib};
          ipv4p_pkg::RX_OCT: acc_d = {acc[28:0], 3'd0} + {28'd0, cls.nib};
          default:           acc_d = {acc[28:0], 3'd0} + {acc[30:0], 1'b0} +
                                     {28'd0, cls.nib};
        endcase
      end else if (cls.is_hex_letter && (radix_d == ipv4p_pkg::RX_HEX)) begin
        acc_d = {acc[27:0], cls.nib};
      end else if (cls.is_dot) begin
        if (cnt == 2'd3) begin
          emit = 1'b1;
        end else begin
          store   = 1'b1;
          cnt_d   = cnt + 2'd1;
          phase_d = ipv4p_pkg::PH_START;
        end
      end else if (cls.is_end) begin
        // The last part fills whatever bytes the earlier parts left free.
        // Earlier parts are shifted into place unchecked: the first keeps only its low byte,
        // and the upper bits of the second and third overlap the bytes above them.
        case (cnt)
          2'd0: begin
            val = acc;
          end
          2'd1: begin
            ok  = (acc <= ipv4p_pkg::MAX_24B);
            val = acc | {parts_q[0][7:0], 24'd0};
          end
          2'd2: begin
            ok  = (acc <= ipv4p_pkg::MAX_16B);
            val = acc | {parts_q[0][7:0], 24'd0} | {parts_q[1][15:0], 16'd0};
          end
          default: begin
            ok  = (acc <= ipv4p_pkg::MAX_8B);
            val = acc | {parts_q[0][7:0], 24'd0} | {parts_q[1][15:0], 16'd0} |
                  {parts_q[2][23:0], 8'd0};
          end
        endcase
        emit        = 1'b1;
        res_valid_d = ok;
        addr_d      = ok ? {val[7:0], val[15:8], val[23:16], val[31:24]} : 32'd0;
      end else begin
        emit = 1'b1;
      end
    end

    if (emit) begin
      phase_d = ipv4p_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ipv4p_pkg::PH_IDLE;
      radix_q     <= ipv4p_pkg::RX_DEC;
      acc_q       <= 32'd0;
      cnt_q       <= 2'd0;
      parts_q[0]  <= 32'd0;
      parts_q[1]  <= 32'd0;
      parts_q[2]  <= 32'd0;
      out_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      addr_q      <= 32'd0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        radix_q <= radix_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        if (store) begin
          parts_q[cnt_d - 2'd1] <= acc_d;
        end
      end
      if (in_fire && emit) begin
        out_valid_q <= 1'b1;
        res_valid_q <= res_valid_d;
        addr_q      <= addr_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.valid_res = res_valid_q;
  assign out_o.address   = addr_q;

  // A result always leaves the parser idle until the next start.
  a_emit_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit) |=> (phase_q == ipv4p_pkg::PH_IDLE))
    else $error("parser not idle after a result");

  // A failed parse reports a zero address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_valid_q) |-> (addr_q == 32'd0))
    else $error("failed result carries a nonzero address");

  // After a leading zero the part value is still zero.
  a_zero_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ipv4p_pkg::PH_ZERO) |-> (acc_q == 32'd0))
    else $error("accumulator nonzero after a leading zero");

endmodule

`default_nettype wire

FILE: sim/ipv4_address_text_parser_tb.sv
// Self-checking testbench for ipv4_address_text_parser: feeds address strings a byte at a
// time, predicts every result with a local parser model and checks them field by field.
// Depends on ipv4p_pkg, ipv4p_in_if, ipv4p_out_if and the RTL of the parser.
`timescale 1ns / 1ps

module ipv4_address_text_parser_tb;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int TEXT_TARGET = 600;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic       lead;
    logic [7:0] ch;
  } text_byte_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } addr_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ipv4p_in_if  in_if ();
  ipv4p_out_if out_if ();

  ipv4_address_text_parser uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  text_byte_t   text_items_q[$];
  addr_result_t expected_addr_q[$];
  logic [7:0]   text_q[$];

  // Parser state as the block should hold it.
  ipv4p_pkg::phase_e ps_phase;
  ipv4p_pkg::radix_e ps_radix;
  logic [31:0] ps_value;
  logic [31:0] ps_parts[3];
  logic [1:0]  ps_count;

  int  errors = 0;
  int  cycles = 0;
  int  in_count = 0;
  int  n_strings = 0;
  int  n_text = 0;
  int  n_results = 0;
  int  n_good = 0;
  logic in_taken = 1'b0;
  logic calm = 1'b0;
  logic quiet_send = 1'b0;
  logic quiet_take = 1'b0;
  int  send_gap = 0;
  int  take_gap = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("MISMATCH at cycle %0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  function automatic bit is_digit(logic [7:0] c);
    return c >= ipv4p_pkg::CH_0 && c <= ipv4p_pkg::CH_9;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == ipv4p_pkg::CH_SPACE || (c >= ipv4p_pkg::CH_TAB && c <= ipv4p_pkg::CH_CR);
  endfunction

  function automatic void close_address(bit ok, logic [31:0] v);
    addr_result_t r;
    r.ok = ok;
    r.addr = ok ? {v[7:0], v[15:8], v[23:16], v[31:24]} : 32'd0;
    expected_addr_q.push_back(r);
    ps_phase = ipv4p_pkg::PH_IDLE;
  endfunction

  // Range check of the last part, then merge with the stored parts.
  function automatic void finish_address();
    logic [31:0] v;
    bit ok;
    v = ps_value;
    ok = 1'b1;
    case (ps_count)
      2'd0: ;
      2'd1: if (v > ipv4p_pkg::MAX_24B) ok = 1'b0;
            else v = v | (ps_parts[0] << 24);
      2'd2: if (v > ipv4p_pkg::MAX_16B) ok = 1'b0;
            else v = v | (ps_parts[0] << 24) | (ps_parts[1] << 16);
      default: if (v > ipv4p_pkg::MAX_8B) ok = 1'b0;
               else v = v | (ps_parts[0] << 24) | (ps_parts[1] << 16) | (ps_parts[2] << 8);
    endcase
    close_address(ok, v);
  endfunction

  function automatic void take_digit(logic [7:0] c);
    logic [31:0] mul;
    logic [7:0]  t;
    if (is_digit(c)) begin
      case (ps_radix)
        ipv4p_pkg::RX_HEX: mul = 32'd16;
        ipv4p_pkg::RX_OCT: mul = 32'd8;
        default: mul = 32'd10;
      endcase
      t = c - ipv4p_pkg::CH_0;
      ps_value = ps_value * mul + {24'd0, t};
    end else if (ps_radix == ipv4p_pkg::RX_HEX && c >= ipv4p_pkg::CH_LA &&
                 c <= ipv4p_pkg::CH_LF_HEX) begin
      t = c - ipv4p_pkg::CH_LA + 8'd10;
      ps_value = (ps_value << 4) | {28'd0, t[3:0]};
    end else if (ps_radix == ipv4p_pkg::RX_HEX && c >= ipv4p_pkg::CH_UA &&
                 c <= ipv4p_pkg::CH_UF) begin
      t = c - ipv4p_pkg::CH_UA + 8'd10;
      ps_value = (ps_value << 4) | {28'd0, t[3:0]};
    end else if (c == ipv4p_pkg::CH_DOT) begin
      if (ps_count == 2'd3) begin
        close_address(1'b0, 32'd0);
      end else begin
        ps_parts[ps_count] = ps_value;
        ps_count = ps_count + 2'd1;
        ps_phase = ipv4p_pkg::PH_START;
      end
    end else if (c == ipv4p_pkg::CH_NUL || is_blank(c)) begin
      finish_address();
    end else begin
      close_address(1'b0, 32'd0);
    end
  endfunction

  function automatic void parse_char(logic lead, logic [7:0] c);
    if (lead) begin
      ps_phase = ipv4p_pkg::PH_START;
      ps_count = 2'd0;
      ps_value = 32'd0;
      ps_radix = ipv4p_pkg::RX_DEC;
    end
    case (ps_phase)
      ipv4p_pkg::PH_START: begin
        if (!is_digit(c)) begin
          close_address(1'b0, 32'd0);
        end else if (c == ipv4p_pkg::CH_0) begin
          ps_value = 32'd0;
          ps_phase = ipv4p_pkg::PH_ZERO;
        end else begin
          ps_value = {24'd0, c - ipv4p_pkg::CH_0};
          ps_radix = ipv4p_pkg::RX_DEC;
          ps_phase = ipv4p_pkg::PH_DIGITS;
        end
      end
      ipv4p_pkg::PH_ZERO: begin
        ps_phase = ipv4p_pkg::PH_DIGITS;
        if (c == ipv4p_pkg::CH_LX || c == ipv4p_pkg::CH_UX) begin
          ps_radix = ipv4p_pkg::RX_HEX;
        end else begin
          ps_radix = ipv4p_pkg::RX_OCT;
          take_digit(c);
        end
      end
      ipv4p_pkg::PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endfunction

  // Moves the staged text into the item queue; only strings that begin with a
  // start flag count toward the stimulus size.
  function automatic void ship(bit lead);
    foreach (text_q[i]) text_items_q.push_back(text_byte_t'{lead && (i == 0), text_q[i]});
    if (lead) begin
      n_strings++;
      n_text += text_q.size();
    end
    text_q.delete();
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_terminator();
    case ($urandom_range(0, 6))
      0: return ipv4p_pkg::CH_NUL;
      1: return ipv4p_pkg::CH_SPACE;
      2: return ipv4p_pkg::CH_TAB;
      3: return ipv4p_pkg::CH_LF;
      4: return ipv4p_pkg::CH_VT;
      5: return ipv4p_pkg::CH_FF;
      default: return ipv4p_pkg::CH_CR;
    endcase
  endfunction

  function automatic void put_part(logic [31:0] v, ipv4p_pkg::radix_e r);
    logic [7:0]  dig[$];
    logic [31:0] t;
    logic [3:0]  nib;
    t = v;
    case (r)
      ipv4p_pkg::RX_HEX: begin
        text_q.push_back(ipv4p_pkg::CH_0);
        text_q.push_back($urandom_range(0, 1) ? ipv4p_pkg::CH_UX : ipv4p_pkg::CH_LX);
        if (t != 0 || $urandom_range(0, 1)) begin
          do begin
            nib = t[3:0];
            if (nib < 4'd10) dig.push_front(ipv4p_pkg::CH_0 + {4'd0, nib});
            else dig.push_front(($urandom_range(0, 1) ? ipv4p_pkg::CH_UA : ipv4p_pkg::CH_LA)
                                + {4'd0, nib} - 8'd10);
            t = t >> 4;
          end while (t != 0);
        end
      end
      ipv4p_pkg::RX_OCT: begin
        text_q.push_back(ipv4p_pkg::CH_0);
        while (t != 0) begin
          dig.push_front(ipv4p_pkg::CH_0 + {5'd0, t[2:0]});
          t = t >> 3;
        end
        // Octal parts still take 8 and 9 as digits.
        if (dig.size() != 0 && $urandom_range(0, 5) == 0)
          dig[$urandom_range(0, dig.size() - 1)] =
            ipv4p_pkg::CH_0 + 8'd8 + 8'($urandom_range(0, 1));
      end
      default: begin
        do begin
          dig.push_front(ipv4p_pkg::CH_0 + 8'(t % 10));
          t = t / 10;
        end while (t != 0);
      end
    endcase
    // Extra digits push the part past 32 bits now and then, so it wraps.
    if ($urandom_range(0, 15) == 0)
      repeat ($urandom_range(1, 4)) dig.push_back(ipv4p_pkg::CH_0 + 8'($urandom_range(0, 7)));
    foreach (dig[i]) text_q.push_back(dig[i]);
  endfunction

  function automatic void queue_address();
    int          parts;
    int          sel;
    logic [31:0] limit;
    logic [31:0] v;
    parts = $urandom_range(1, 4);
    for (int i = 0; i < parts; i++) begin
      if (i > 0) text_q.push_back(ipv4p_pkg::CH_DOT);
      if (i < parts - 1) begin
        v = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 255);
      end else begin
        case (parts)
          1: limit = 32'hffff_ffff;
          2: limit = ipv4p_pkg::MAX_24B;
          3: limit = ipv4p_pkg::MAX_16B;
          default: limit = ipv4p_pkg::MAX_8B;
        endcase
        case ($urandom_range(0, 9))
          0: v = limit;
          1: v = limit + 32'd1;
          2: v = $urandom();
          default: v = $urandom_range(0, limit);
        endcase
      end
      put_part(v, ipv4p_pkg::radix_e'($urandom_range(0, 2)));
    end
    sel = $urandom_range(0, 11);
    if (sel == 0) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    if (sel == 2) begin
      text_q.push_back(ipv4p_pkg::CH_DOT);
      put_part($urandom_range(0, 255), ipv4p_pkg::RX_DEC);
    end
    if (sel != 1) text_q.push_back(pick_terminator());
    ship(1'b1);
    // Bytes after the end of a string must be ignored.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      ship(1'b0);
    end
  endfunction

  // Sender: presents the head of the item queue, with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // The offered item has not been taken yet; hold it.
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_if.valid <= 1'b0;
    end else if (text_items_q.size() == 0) begin
      in_if.valid <= 1'b0;
    end else if (!calm && !quiet_send && hold_left == 0 && $urandom_range(0, 6) == 0) begin
      send_gap <= $urandom_range(0, 13);
      in_if.valid <= 1'b0;
    end else begin
      in_if.valid <= 1'b1;
      in_if.start_req <= text_items_q[0].lead;
      in_if.character <= text_items_q[0].ch;
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && in_count >= 250) begin
      hold_done <= 1'b1;
      hold_left <= 119;
      out_if.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap <= take_gap - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && !quiet_take && $urandom_range(0, 5) == 0) begin
      take_gap <= $urandom_range(0, 13);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: checks results first, since a result never stems from an item
  // taken at the same edge, then runs accepted items through the model.
  always @(posedge clk_i or negedge rst_ni) begin
    addr_result_t want;
    if (!rst_ni) begin
      ps_phase = ipv4p_pkg::PH_IDLE;
      ps_radix = ipv4p_pkg::RX_DEC;
      ps_value = 32'd0;
      ps_count = 2'd0;
      foreach (ps_parts[i]) ps_parts[i] = 32'd0;
      in_taken <= 1'b0;
    end else if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycles, expected_addr_q.size());
      $display("ipv4_address_text_parser verification failed");
      $finish;
    end else begin
      cycles++;
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (expected_addr_q.size() == 0) begin
          report_mismatch("unexpected result, address", out_if.address, 32'd0);
        end else begin
          want = expected_addr_q.pop_front();
          if (want.ok) n_good++;
          if (out_if.valid_res !== want.ok)
            report_mismatch("valid_res", {31'd0, out_if.valid_res}, {31'd0, want.ok});
          if (out_if.address !== want.addr)
            report_mismatch("address", out_if.address, want.addr);
        end
      end
      if (in_if.valid && in_if.ready) begin
        parse_char(in_if.start_req, in_if.character);
        void'(text_items_q.pop_front());
        in_count++;
      end
      in_taken <= in_if.valid && in_if.ready;
      calm <= text_items_q.size() < 80;
      if (cycles % 150 == 0) begin
        quiet_send <= $urandom_range(0, 2) == 0;
        quiet_take <= $urandom_range(0, 2) == 0;
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.start_req = 1'b0;
    in_if.character = 8'd0;
    out_if.ready = 1'b0;

    // A byte with no start while idle is dropped.
    queue_text("A");
    ship(1'b0);
    // Bare hex prefix reads as zero.
    queue_text("0x");
    text_q.push_back(ipv4p_pkg::CH_NUL);
    ship(1'b1);
    // Octal part with a 9 in it.
    queue_text("09 ");
    ship(1'b1);
    // A new start drops the unfinished string; a non-digit start fails.
    queue_text("9.");
    ship(1'b1);
    text_q.push_back(8'hff);
    ship(1'b1);
    // Bad character after the digits.
    queue_text("1g");
    ship(1'b1);
    // Last of four parts over 255.
    queue_text("0.0.0.256");
    text_q.push_back(ipv4p_pkg::CH_FF);
    ship(1'b1);
    // A fifth part is refused.
    queue_text("1.2.3.4.");
    ship(1'b1);

    while (n_text < TEXT_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(0, 255)));
        ship(1'b1);
      end else begin
        queue_address();
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (text_items_q.size() != 0 || expected_addr_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Fed %0d strings (%0d text bytes, %0d bytes accepted) in %0d cycles.",
             n_strings, n_text, in_count, cycles);
    $display("Checked %0d results, %0d of them well-formed addresses; %0d mismatches.",
             n_results, n_good, errors);
    if (errors == 0 && expected_addr_q.size() == 0) begin
      $display("ipv4_address_text_parser verification clean");
    end else begin
      $display("ipv4_address_text_parser verification failed");
    end
    $finish;
  end

endmodule
